FILE: rtl/core/ffc_pkg.sv
`default_nettype none

package ffc_pkg;

    localparam int unsigned WordWidth  = 32;
    localparam int unsigned MagWidth   = 31;
    localparam int unsigned ExpWidth   = 8;
    localparam int unsigned TallyWidth = 32;

    // Direction codes for func
    localparam logic FuncVaxToIeee = 1'b0;
    localparam logic FuncIeeeToVax = 1'b1;

    localparam logic [MagWidth-1:0] ExpOne  = 31'h0080_0000;
    localparam logic [MagWidth-1:0] ExpTwo  = 31'h0100_0000;
    localparam logic [MagWidth-1:0] VaxMax  = 31'h7fff_ffff;
    localparam logic [ExpWidth-1:0] ExpSat  = 8'd254;
    localparam logic [ExpWidth-1:0] ExpTwoC = 8'd2;
    localparam logic [ExpWidth-1:0] ExpThr  = 8'd3;
    localparam logic [TallyWidth-1:0] TallyMax = '1;

    typedef struct packed {
        logic                 func;
        logic [WordWidth-1:0] word_in;
        logic                 last_in_array;
    } ffc_item_t;

    typedef struct packed {
        logic [WordWidth-1:0]  word_out;
        logic                  saturated;
        logic [TallyWidth-1:0] saturated_total;
        logic                  array_done;
    } ffc_result_t;

    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic                 saturated;
    } ffc_conv_t;

    typedef struct packed {
        logic step;
        logic flag;
        logic last;
    } ffc_tally_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/f_float_ieee_single_converter_top.sv
`default_nettype none

// Converts one 32-bit float per beat between VAX F and IEEE single, both in
// logical field order (sign 31, exponent 30:23, fraction 22:0); func 0 goes
// VAX to IEEE, func 1 IEEE to VAX. One beat is taken every cycle while result_ready
// does not stall the output; each beat moves from the input register through
// the conversion logic into the result register. IEEE
// values too large for VAX saturate and are flagged, and a per-array count of
// flagged beats rides with each result and clears after the beat marked
// last_in_array.
module f_float_ieee_single_converter_top (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          item_valid,
    output logic                         item_ready,
    input  wire ffc_pkg::ffc_item_t      item,
    output logic                         result_valid,
    input  wire                          result_ready,
    output ffc_pkg::ffc_result_t         result
);

    logic                           s1_valid_reg;
    ffc_pkg::ffc_item_t             s1_data_reg;
    logic                           result_valid_reg;
    ffc_pkg::ffc_result_t           result_reg;
    logic                           s2_load;
    ffc_pkg::ffc_conv_t             conv;
    ffc_pkg::ffc_tally_ctl_t        tally_ctl;
    logic [ffc_pkg::TallyWidth-1:0] tally_total;
    logic [ffc_pkg::TallyWidth-1:0] tally_count;

    assign s2_load    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || s2_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item_valid && item_ready)
            s1_valid_reg <= 1'b1;
        else if (s2_load)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            s1_data_reg <= item;
    end

    ffc_convert u_convert (
        .item (s1_data_reg),
        .conv (conv)
    );

    assign tally_ctl.step = s2_load;
    assign tally_ctl.flag = conv.saturated;
    assign tally_ctl.last = s1_data_reg.last_in_array;

    ffc_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (tally_ctl),
        .total (tally_total),
        .count (tally_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s2_load)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            result_reg.word_out        <= conv.word;
            result_reg.saturated       <= conv.saturated;
            result_reg.saturated_total <= tally_total;
            result_reg.array_done      <= s1_data_reg.last_in_array;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef ASSERT_OFF
    // Hold the staged beat until the result register takes it
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("staged beat changed before advancing");

    a_sat_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            result.saturated_total != '0 && result.word_out[30:0] == ffc_pkg::VaxMax)
        else $error("saturated result without max word or count");

    a_tally_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load && s1_data_reg.last_in_array |=> tally_count == '0)
        else $error("count not cleared after last beat of array");

    a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_load |=> $stable(tally_count))
        else $error("count moved without a beat advancing");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ffc_convert.sv
`default_nettype none

module ffc_convert (
    input  wire ffc_pkg::ffc_item_t item,
    output ffc_pkg::ffc_conv_t      conv
);

    logic                            sign;
    logic [ffc_pkg::MagWidth-1:0]    mag;
    logic [ffc_pkg::ExpWidth-1:0]    expo;
    logic [ffc_pkg::MagWidth-1:0]    v2i_mag;
    logic [ffc_pkg::MagWidth-1:0]    i2v_mag;
    logic [ffc_pkg::MagWidth-1:0]    v2i_lo;
    logic [ffc_pkg::MagWidth-1:0]    v2i_two;
    logic                            i2v_tiny;
    logic                            i2v_sat;

    assign sign = item.word_in[ffc_pkg::WordWidth-1];
    assign mag  = item.word_in[ffc_pkg::MagWidth-1:0];
    assign expo = mag[ffc_pkg::MagWidth-1 -: ffc_pkg::ExpWidth];

    assign v2i_lo  = (mag + 31'd1) >> 2;
    assign v2i_two = (mag - ffc_pkg::ExpOne) >> 1;

    always_comb
    begin
        priority if (expo >= ffc_pkg::ExpThr)
            v2i_mag = mag - ffc_pkg::ExpTwo;
        else if (expo == ffc_pkg::ExpTwoC)
            v2i_mag = v2i_two;
        else
            v2i_mag = v2i_lo;
    end

    // Tiny IEEE values, signed zero included, collapse to a plain zero
    assign i2v_tiny = (mag[ffc_pkg::MagWidth-1:21] == '0);
    assign i2v_sat  = !i2v_tiny && (expo >= ffc_pkg::ExpSat);

    always_comb
    begin
        priority if (i2v_sat)
            i2v_mag = ffc_pkg::VaxMax;
        else if (expo != '0)
            i2v_mag = mag + ffc_pkg::ExpTwo;
        else if (mag[22])
            i2v_mag = (mag << 1) + ffc_pkg::ExpOne;
        else
            i2v_mag = mag << 2;
    end

    always_comb
    begin
        unique case (item.func)
            ffc_pkg::FuncVaxToIeee:
            begin
                conv.word      = {sign, v2i_mag};
                conv.saturated = 1'b0;
            end
            ffc_pkg::FuncIeeeToVax:
            begin
                conv.word      = i2v_tiny ? '0 : {sign, i2v_mag};
                conv.saturated = i2v_sat;
            end
            default:
            begin
                conv.word      = '0;
                conv.saturated = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ffc_tally.sv
`default_nettype none

module ffc_tally (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire ffc_pkg::ffc_tally_ctl_t     ctl,
    output logic [ffc_pkg::TallyWidth-1:0]   total,
    output logic [ffc_pkg::TallyWidth-1:0]   count
);

    logic [ffc_pkg::TallyWidth-1:0] tally_reg;
    logic [ffc_pkg::TallyWidth-1:0] tally_next;

    // Saturate at all ones rather than wrap
    assign total = (ctl.flag && tally_reg != ffc_pkg::TallyMax) ?
                   tally_reg + 32'd1 : tally_reg;

    always_comb
    begin
        tally_next = tally_reg;
        if (ctl.step)
            tally_next = ctl.last ? '0 : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tally_reg <= '0;
        else
            tally_reg <= tally_next;
    end

    assign count = tally_reg;

endmodule

`default_nettype wire

FILE: tb/sv/tb_f_float_ieee_single_converter_top.sv
`timescale 1ns / 1ps

module tb_f_float_ieee_single_converter_top;

    import ffc_pkg::*;

    localparam int unsigned RandomWords  = 1330;
    localparam int unsigned CalmStart    = 500;
    localparam int unsigned CalmEnd      = 750;
    localparam int unsigned DrainAt      = 900;
    localparam int unsigned StallPercent = 18;
    localparam int unsigned WatchLimit   = 1000;
    localparam int unsigned TailCycles   = 8;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    ffc_item_t   item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    ffc_result_t result;

    ffc_item_t   float_queue[$];
    ffc_result_t expected_results[$];

    logic [TallyWidth-1:0] sat_tally = '0;
    logic        in_beat    = 1'b0;
    logic        timed_out  = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned sent_count  = 0;
    int unsigned word_count  = 0;
    int unsigned sat_count   = 0;
    int unsigned array_count = 0;
    int unsigned err_count   = 0;

    f_float_ieee_single_converter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic ffc_conv_t convert_word(logic dir, logic [WordWidth-1:0] w);
        logic [MagWidth-1:0]  m;
        logic [ExpWidth-1:0]  e;
        logic [WordWidth-1:0] r;
        logic                 sat;
        ffc_conv_t            c;
        m   = w[MagWidth-1:0];
        e   = m[30:23];
        sat = 1'b0;
        if (dir == FuncVaxToIeee)
        begin
            if (e >= ExpThr)
                r = {1'b0, m - ExpTwo};
            else if (e == ExpTwoC)
                r = {1'b0, m - ExpOne} >> 1;
            else
                r = ({1'b0, m} + 32'd1) >> 2;
            r[31] = w[31];
        end
        else
        begin
            // tiny values drop the sign: VAX negative zero is reserved
            if (m[30:21] == '0)
                r = '0;
            else if (e >= ExpSat)
            begin
                r   = {w[31], VaxMax};
                sat = 1'b1;
            end
            else if (e != '0)
                r = {w[31], m + ExpTwo};
            else if (m[22])
                r = {w[31], (m << 1) + ExpOne};
            else
                r = {w[31], m << 2};
        end
        c.word      = r;
        c.saturated = sat;
        return c;
    endfunction

    function automatic ffc_item_t random_float_item();
        ffc_item_t             it;
        logic [ExpWidth-1:0]   e;
        logic [WordWidth-1:0]  bits;
        int unsigned           kind;
        bits = $urandom;
        kind = $urandom_range(9);
        case (kind)
            0: e = 8'd0;
            1: e = 8'd1;
            2: e = 8'd2;
            3: e = 8'd3;
            4: e = 8'd253;
            5: e = 8'd254;
            6: e = 8'd255;
            default: e = bits[30:23];
        endcase
        it.func    = 1'($urandom_range(1));
        it.word_in = {bits[31], e, bits[22:0]};
        // clear bits 30:21 to hit the tiny-value path
        if (kind == 7)
            it.word_in[30:21] = '0;
        it.last_in_array = ($urandom_range(15) == 0);
        return it;
    endfunction

    task automatic queue_word(logic dir, logic [WordWidth-1:0] w, logic last);
        ffc_item_t it;
        it.func          = dir;
        it.word_in       = w;
        it.last_in_array = last;
        float_queue.push_back(it);
    endtask

    task automatic check_result(ffc_result_t got);
        ffc_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            err_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.word_out !== want.word_out)
            begin
                $display("%0t: word_out expected %h actual %h",
                         $time, want.word_out, got.word_out);
                err_count++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %b actual %b",
                         $time, want.saturated, got.saturated);
                err_count++;
            end
            if (got.saturated_total !== want.saturated_total)
            begin
                $display("%0t: saturated_total expected %0d actual %0d",
                         $time, want.saturated_total, got.saturated_total);
                err_count++;
            end
            if (got.array_done !== want.array_done)
            begin
                $display("%0t: array_done expected %b actual %b",
                         $time, want.array_done, got.array_done);
                err_count++;
            end
        end
    endtask

    // Monitor: predict on each accepted input beat, check each result beat.
    always @(posedge clk)
    begin
        ffc_conv_t   c;
        ffc_result_t r;
        in_beat <= item_valid && item_ready;
        if (rst_n && item_valid && item_ready)
        begin
            c = convert_word(item.func, item.word_in);
            if (c.saturated && sat_tally != TallyMax)
                sat_tally = sat_tally + 1'b1;
            r.word_out        = c.word;
            r.saturated       = c.saturated;
            r.saturated_total = sat_tally;
            r.array_done      = item.last_in_array;
            expected_results.push_back(r);
            word_count++;
            if (c.saturated)
                sat_count++;
            if (item.last_in_array)
            begin
                sat_tally = '0;
                array_count++;
            end
        end
        if (rst_n && result_valid && result_ready)
            check_result(result);
    end

    // Driver: advance on acceptance, insert random gaps on both sides.
    always @(negedge clk)
    begin
        logic calm;
        logic hold;
        if (rst_n)
        begin
            calm = (sent_count >= CalmStart) && (sent_count < CalmEnd);
            if (!item_valid || in_beat)
            begin
                // hold the sender once until every result is back
                hold = (sent_count == DrainAt) && (expected_results.size() != 0);
                if (float_queue.size() != 0 && !hold
                    && (calm || $urandom_range(99) >= StallPercent))
                begin
                    item       <= float_queue.pop_front();
                    item_valid <= 1'b1;
                    sent_count <= sent_count + 1;
                end
                else
                    item_valid <= 1'b0;
            end
            result_ready <= calm || ($urandom_range(99) >= StallPercent);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
            timed_out <= 1'b1;
    end

    initial
    begin
        // VAX to IEEE: each exponent class, signs, extremes
        queue_word(FuncVaxToIeee, 32'h0000_0000, 1'b0);
        queue_word(FuncVaxToIeee, 32'h8000_0000, 1'b0);
        queue_word(FuncVaxToIeee, 32'h007f_ffff, 1'b0);
        queue_word(FuncVaxToIeee, 32'h0080_0000, 1'b0);
        queue_word(FuncVaxToIeee, 32'h80ff_ffff, 1'b0);
        queue_word(FuncVaxToIeee, 32'h0100_0000, 1'b0);
        queue_word(FuncVaxToIeee, 32'h817f_ffff, 1'b0);
        queue_word(FuncVaxToIeee, 32'h0180_0000, 1'b0);
        queue_word(FuncVaxToIeee, 32'h7fff_ffff, 1'b0);
        queue_word(FuncVaxToIeee, 32'hffff_ffff, 1'b1);
        // IEEE to VAX: zeros, tiny, denormals, normal, saturation, inf, NaN
        queue_word(FuncIeeeToVax, 32'h0000_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h8000_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h801f_ffff, 1'b0);
        queue_word(FuncIeeeToVax, 32'h0020_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h0040_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h807f_ffff, 1'b0);
        queue_word(FuncIeeeToVax, 32'h0080_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h7eff_ffff, 1'b0);
        queue_word(FuncIeeeToVax, 32'h7f00_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'hff80_0000, 1'b0);
        queue_word(FuncIeeeToVax, 32'h7fc0_0001, 1'b0);
        queue_word(FuncIeeeToVax, 32'hffff_ffff, 1'b1);
        queue_word(FuncIeeeToVax, 32'h7f80_0000, 1'b0);
        for (int unsigned i = 0; i < RandomWords; i++)
            float_queue.push_back(random_float_item());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!timed_out && !(float_queue.size() == 0 && !item_valid
                               && expected_results.size() == 0))
            @(posedge clk);
        if (!timed_out)
            repeat (TailCycles) @(posedge clk);

        $display("Converted %0d words in both directions, %0d saturated, %0d arrays closed",
                 word_count, sat_count, array_count);
        $display("Mismatches: %0d, results outstanding: %0d",
                 err_count, expected_results.size());
        if (timed_out || err_count != 0 || expected_results.size() != 0)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end

endmodule
